// ===== design/euler_to_quaternion_macros.svh =====
// Assertion macros used by the euler_to_quaternion top-level design file.
`ifndef EULER_TO_QUATERNION_MACROS_SVH
`define EULER_TO_QUATERNION_MACROS_SVH

// Property checked on every rising edge of aclk outside reset.
`define E2Q_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Property checked on every rising edge of aclk, reset included.
`define E2Q_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== design/e2q_pkg.sv =====
// Types, constants and the arctangent table of the Euler-to-quaternion block.
package e2q_pkg;

    localparam int ANGLE_FRAC_BITS = 13;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int TRIG_ITERATIONS = 16;
    localparam int WORK_FRAC       = 30;
    localparam int HALF_SHIFT      = WORK_FRAC - 1 - ANGLE_FRAC_BITS;
    localparam int OUT_SHIFT       = 2 * WORK_FRAC - OUT_FRAC_BITS;

    localparam int LANE_W = 34;
    localparam int NUM_LANES = 3;
    localparam int LANE_YAW   = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_ROLL  = 2;

    typedef logic signed [LANE_W-1:0] lane_t;
    typedef logic signed [31:0] q30_t;
    typedef logic signed [63:0] q60_t;
    typedef logic signed [64:0] q65_t;

    localparam lane_t PI_Q30      = 34'sd3373259426;
    localparam lane_t HALF_PI_Q30 = 34'sd1686629713;
    localparam lane_t GAIN_Q30    = 34'sd652032874;

    localparam lane_t ATAN_Q30 [0:31] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127,
        34'sd63,        34'sd31,        34'sd15,        34'sd7,
        34'sd3,         34'sd1,         34'sd0,         34'sd0
    };

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } angles_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } quat_t;

    typedef struct packed {
        lane_t x;
        lane_t y;
        lane_t z;
        logic  neg;
    } cordic_lane_t;

    typedef cordic_lane_t [NUM_LANES-1:0] cordic_bus_t;

    typedef struct packed {
        q30_t c;
        q30_t s;
    } trig_lane_t;

    typedef trig_lane_t [NUM_LANES-1:0] trig_bus_t;

endpackage

// ===== design/euler_to_quaternion.sv =====
// Pipeline: 1 fold, 16 CORDIC, 1 sign and 4 combine stages, each registered.
// Throughput: one item per cycle while m_ready holds; every pipeline stage holds its own valid bit.
// The CORDIC chain (one rotation per stage) sets the depth; the combine block adds four stages.
// Backpressure: a stage advances when empty or when the one after it advances.
// Reset: synchronous, active low on aresetn; clears all stage valid bits, no result pending.
module euler_to_quaternion import e2q_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  angles_t s_data,
    output logic    m_valid,
    input  logic    m_ready,
    output quat_t   m_data
);

`include "euler_to_quaternion_macros.svh"

    // trig front end to product back end handshake
    logic      trig_valid;
    logic      trig_ready;
    trig_bus_t trig_bus;

    // Fold each half angle, rotate through the CORDIC chain and restore the sign.
    // Lane order inside the bus is yaw, pitch, roll.
    e2q_trig u_trig (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_angles(s_data),
        .out_valid(trig_valid),
        .out_ready(trig_ready),
        .out_trig (trig_bus)
    );

    // Form the ZYX products, add the term pairs, round and clamp.
    // The last stage here is the output register seen on m_data.
    e2q_combine u_combine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (trig_valid),
        .in_ready (trig_ready),
        .in_trig  (trig_bus),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_quat (m_data)
    );

    // An empty output stage means every stage can advance, so input is open.
    `E2Q_ASSERT(a_idle_accepts, !m_valid |-> s_ready, "input stalled with empty output")

    // Every shown component lies within plus or minus one.
    `E2Q_ASSERT(a_unit_range, m_valid |-> (m_data.quat_w <= 16'sd16384 && m_data.quat_w >= -16'sd16384 && m_data.quat_x <= 16'sd16384 && m_data.quat_x >= -16'sd16384 && m_data.quat_y <= 16'sd16384 && m_data.quat_y >= -16'sd16384 && m_data.quat_z <= 16'sd16384 && m_data.quat_z >= -16'sd16384), "quaternion component out of range")

    // Reset drops every item in flight.
    `E2Q_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

// ===== design/e2q_cordic_stage.sv =====
// One registered CORDIC rotation step applied to all three angle lanes.
module e2q_cordic_stage import e2q_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  cordic_bus_t in_bus,
    output logic        out_valid,
    input  logic        out_ready,
    output cordic_bus_t out_bus
);

    logic        valid_reg;
    cordic_bus_t bus_reg;
    cordic_bus_t bus_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_bus   = bus_reg;

    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            bus_next[k].neg = in_bus[k].neg;
            if (!in_bus[k].z[LANE_W-1]) begin
                bus_next[k].x = in_bus[k].x - (in_bus[k].y >>> STAGE);
                bus_next[k].y = in_bus[k].y + (in_bus[k].x >>> STAGE);
                bus_next[k].z = in_bus[k].z - ATAN_Q30[STAGE];
            end else begin
                bus_next[k].x = in_bus[k].x + (in_bus[k].y >>> STAGE);
                bus_next[k].y = in_bus[k].y - (in_bus[k].x >>> STAGE);
                bus_next[k].z = in_bus[k].z + ATAN_Q30[STAGE];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            bus_reg <= bus_next;
        end
    end

endmodule

// ===== design/e2q_trig.sv =====
// Half-angle fold, CORDIC chain and sign fix giving cosine and sine of three angles.
module e2q_trig import e2q_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  angles_t   in_angles,
    output logic      out_valid,
    input  logic      out_ready,
    output trig_bus_t out_trig
);

    logic        fold_valid_reg;
    cordic_bus_t fold_reg;
    cordic_bus_t fold_next;
    logic        fold_ready;

    logic        stg_valid [0:TRIG_ITERATIONS];
    logic        stg_ready [0:TRIG_ITERATIONS];
    cordic_bus_t stg_bus   [0:TRIG_ITERATIONS];

    logic      sign_valid_reg;
    trig_bus_t sign_reg;
    trig_bus_t sign_next;
    logic      sign_ready;

    logic signed [15:0] raw [NUM_LANES];
    lane_t              ang [NUM_LANES];

    assign raw[LANE_YAW]   = in_angles.yaw_angle;
    assign raw[LANE_PITCH] = in_angles.pitch_angle;
    assign raw[LANE_ROLL]  = in_angles.roll_angle;

    // fold each half angle into [-pi/2, pi/2]
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            ang[k] = lane_t'(raw[k]) <<< HALF_SHIFT;
            fold_next[k].x = GAIN_Q30;
            fold_next[k].y = '0;
            if (ang[k] > HALF_PI_Q30) begin
                fold_next[k].z   = ang[k] - PI_Q30;
                fold_next[k].neg = 1'b1;
            end else if (ang[k] < -HALF_PI_Q30) begin
                fold_next[k].z   = ang[k] + PI_Q30;
                fold_next[k].neg = 1'b1;
            end else begin
                fold_next[k].z   = ang[k];
                fold_next[k].neg = 1'b0;
            end
        end
    end

    assign fold_ready = !fold_valid_reg || stg_ready[0];
    assign in_ready   = fold_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
        end else if (fold_ready) begin
            fold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (fold_ready && in_valid) begin
            fold_reg <= fold_next;
        end
    end

    assign stg_valid[0] = fold_valid_reg;
    assign stg_bus[0]   = fold_reg;

    for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_stage
        e2q_cordic_stage #(
            .STAGE(i)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (stg_valid[i]),
            .in_ready (stg_ready[i]),
            .in_bus   (stg_bus[i]),
            .out_valid(stg_valid[i+1]),
            .out_ready(stg_ready[i+1]),
            .out_bus  (stg_bus[i+1])
        );
    end

    // undo the fold by negating both results
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            if (stg_bus[TRIG_ITERATIONS][k].neg) begin
                sign_next[k].c = q30_t'(-stg_bus[TRIG_ITERATIONS][k].x);
                sign_next[k].s = q30_t'(-stg_bus[TRIG_ITERATIONS][k].y);
            end else begin
                sign_next[k].c = q30_t'(stg_bus[TRIG_ITERATIONS][k].x);
                sign_next[k].s = q30_t'(stg_bus[TRIG_ITERATIONS][k].y);
            end
        end
    end

    assign sign_ready = !sign_valid_reg || out_ready;
    assign stg_ready[TRIG_ITERATIONS] = sign_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sign_valid_reg <= 1'b0;
        end else if (sign_ready) begin
            sign_valid_reg <= stg_valid[TRIG_ITERATIONS];
        end
    end

    always_ff @(posedge aclk) begin
        if (sign_ready && stg_valid[TRIG_ITERATIONS]) begin
            sign_reg <= sign_next;
        end
    end

    assign out_valid = sign_valid_reg;
    assign out_trig  = sign_reg;

endmodule

// ===== design/e2q_combine.sv =====
// Product, sum and output rounding stages forming the quaternion from the trig values.
module e2q_combine import e2q_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  trig_bus_t in_trig,
    output logic      out_valid,
    input  logic      out_ready,
    output quat_t     out_quat
);

    localparam int NSTG = 4;
    localparam q65_t ROUND_ADD = q65_t'(1) <<< (OUT_SHIFT - 1);
    localparam q65_t ONE_Q     = q65_t'(1) <<< OUT_FRAC_BITS;

    logic valid_reg [NSTG];
    logic rdy [0:NSTG];

    // stage 1: roll-pitch pair products, yaw terms delayed
    q30_t cc_reg, ss_reg, sc_reg, cs_reg, cy_reg, sy_reg;
    q60_t cc_full, ss_full, sc_full, cs_full;

    // stage 2: yaw products
    q60_t cc_cy_reg, cc_sy_reg, ss_cy_reg, ss_sy_reg;
    q60_t sc_cy_reg, sc_sy_reg, cs_cy_reg, cs_sy_reg;

    // stage 3: sums
    q65_t w_reg, x_reg, y_reg, z_reg;

    // stage 4: rounded and clamped output
    quat_t quat_reg;
    quat_t quat_next;
    q65_t  sum_in [4];

    always_comb begin
        rdy[NSTG] = out_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSTG; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign cc_full = in_trig[LANE_ROLL].c * in_trig[LANE_PITCH].c;
    assign ss_full = in_trig[LANE_ROLL].s * in_trig[LANE_PITCH].s;
    assign sc_full = in_trig[LANE_ROLL].s * in_trig[LANE_PITCH].c;
    assign cs_full = in_trig[LANE_ROLL].c * in_trig[LANE_PITCH].s;

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            cc_reg <= q30_t'(cc_full >>> WORK_FRAC);
            ss_reg <= q30_t'(ss_full >>> WORK_FRAC);
            sc_reg <= q30_t'(sc_full >>> WORK_FRAC);
            cs_reg <= q30_t'(cs_full >>> WORK_FRAC);
            cy_reg <= in_trig[LANE_YAW].c;
            sy_reg <= in_trig[LANE_YAW].s;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1] && valid_reg[0]) begin
            cc_cy_reg <= q60_t'(cc_reg) * q60_t'(cy_reg);
            cc_sy_reg <= q60_t'(cc_reg) * q60_t'(sy_reg);
            ss_cy_reg <= q60_t'(ss_reg) * q60_t'(cy_reg);
            ss_sy_reg <= q60_t'(ss_reg) * q60_t'(sy_reg);
            sc_cy_reg <= q60_t'(sc_reg) * q60_t'(cy_reg);
            sc_sy_reg <= q60_t'(sc_reg) * q60_t'(sy_reg);
            cs_cy_reg <= q60_t'(cs_reg) * q60_t'(cy_reg);
            cs_sy_reg <= q60_t'(cs_reg) * q60_t'(sy_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2] && valid_reg[1]) begin
            w_reg <= q65_t'(cc_cy_reg) + q65_t'(ss_sy_reg);
            x_reg <= q65_t'(sc_cy_reg) - q65_t'(cs_sy_reg);
            y_reg <= q65_t'(cs_cy_reg) + q65_t'(sc_sy_reg);
            z_reg <= q65_t'(cc_sy_reg) - q65_t'(ss_cy_reg);
        end
    end

    assign sum_in[0] = w_reg;
    assign sum_in[1] = x_reg;
    assign sum_in[2] = y_reg;
    assign sum_in[3] = z_reg;

    // round half up, then clamp to plus or minus one
    always_comb begin
        q65_t r [4];
        for (int k = 0; k < 4; k++) begin
            r[k] = (sum_in[k] + ROUND_ADD) >>> OUT_SHIFT;
            if (r[k] > ONE_Q) begin
                r[k] = ONE_Q;
            end else if (r[k] < -ONE_Q) begin
                r[k] = -ONE_Q;
            end
        end
        quat_next.quat_w = r[0][15:0];
        quat_next.quat_x = r[1][15:0];
        quat_next.quat_y = r[2][15:0];
        quat_next.quat_z = r[3][15:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy[3] && valid_reg[2]) begin
            quat_reg <= quat_next;
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign out_quat  = quat_reg;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the Euler-angle to quaternion pipeline.
`timescale 1ns / 1ps

module testbench;
    import e2q_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_ITEMS   = 100;
    localparam int DRAIN_CYCLES = 60;

    logic    aclk = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    angles_t s_data = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    quat_t   m_data;

    angles_t pending_angles[$];
    quat_t   expected_quats[$];
    int      fail_count = 0;
    bit      stimulus_done = 1'b0;
    bit      calm_phase = 1'b0;
    bit      in_taken = 1'b0;
    int      send_gap = 0;
    int      recv_stall = 0;

    euler_to_quaternion dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Floor shift on a signed 64-bit value; >>> on signed already floors.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Cosine and sine of a Q30 half angle by rotation-mode CORDIC.
    function automatic void half_angle_trig(input longint ang, output longint c,
                                            output longint s);
        longint two_pi, px, py, pz, nx;
        bit     flip;
        two_pi = 2 * longint'(PI_Q30);
        px = longint'(GAIN_Q30);
        py = 0;
        flip = 1'b0;
        pz = ang % two_pi;
        if (pz > longint'(PI_Q30)) pz -= two_pi;
        if (pz < -longint'(PI_Q30)) pz += two_pi;
        if (pz > longint'(HALF_PI_Q30)) begin
            pz -= longint'(PI_Q30);
            flip = 1'b1;
        end else if (pz < -longint'(HALF_PI_Q30)) begin
            pz += longint'(PI_Q30);
            flip = 1'b1;
        end
        for (int i = 0; i < TRIG_ITERATIONS && i < 32; i++) begin
            if (pz >= 0) begin
                nx = px - floor_shift(py, i);
                py = py + floor_shift(px, i);
                pz -= longint'(ATAN_Q30[i]);
            end else begin
                nx = px + floor_shift(py, i);
                py = py - floor_shift(px, i);
                pz += longint'(ATAN_Q30[i]);
            end
            px = nx;
        end
        c = flip ? -px : px;
        s = flip ? -py : py;
    endfunction

    function automatic longint triple_product(longint a, longint b, longint c);
        return floor_shift(a * b, WORK_FRAC) * c;
    endfunction

    // Round half up to the output format and clamp at plus or minus one.
    function automatic logic signed [15:0] round_clamp(longint q60);
        longint one, v;
        one = longint'(1) << OUT_FRAC_BITS;
        v = floor_shift(q60 + (longint'(1) << (OUT_SHIFT - 1)), OUT_SHIFT);
        if (v > one) v = one;
        if (v < -one) v = -one;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic quat_t zyx_quaternion(angles_t a);
        longint cy, sy, cp, sp, cr, sr, scale;
        quat_t  q;
        scale = longint'(1) << HALF_SHIFT;
        half_angle_trig(longint'(a.yaw_angle) * scale, cy, sy);
        half_angle_trig(longint'(a.pitch_angle) * scale, cp, sp);
        half_angle_trig(longint'(a.roll_angle) * scale, cr, sr);
        q.quat_w = round_clamp(triple_product(cr, cp, cy) + triple_product(sr, sp, sy));
        q.quat_x = round_clamp(triple_product(sr, cp, cy) - triple_product(cr, sp, sy));
        q.quat_y = round_clamp(triple_product(cr, sp, cy) + triple_product(sr, cp, sy));
        q.quat_z = round_clamp(triple_product(cr, cp, sy) - triple_product(sr, sp, cy));
        return q;
    endfunction

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 65535));
            3: return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'(int'($urandom_range(0, 51472)) - 25736);
        endcase
    endfunction

    // Driver: hold valid and payload until taken; random idle and m_ready stalls.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !in_taken) begin
                // hold the current item
            end else if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
                send_gap <= $urandom_range(0, 12);
                s_valid <= 1'b0;
            end else if (pending_angles.size() > 0) begin
                s_valid <= 1'b1;
                s_data <= pending_angles[0];
            end else begin
                s_valid <= 1'b0;
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_ready <= 1'b0;
            end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
                recv_stall <= $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: predict on input accept, compare on result accept.
    always @(posedge aclk) begin
        quat_t want;
        in_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_quats.push_back(zyx_quaternion(s_data));
                void'(pending_angles.pop_front());
                in_taken = 1'b1;
            end
            if (m_valid && m_ready) begin
                if (expected_quats.size() == 0) begin
                    $display("%0t: result with none expected, actual %h", $time, m_data);
                    fail_count++;
                end else begin
                    want = expected_quats.pop_front();
                    if (m_data.quat_w !== want.quat_w) begin
                        $display("%0t: quat_w expected %0d actual %0d", $time, want.quat_w, m_data.quat_w);
                        fail_count++;
                    end
                    if (m_data.quat_x !== want.quat_x) begin
                        $display("%0t: quat_x expected %0d actual %0d", $time, want.quat_x, m_data.quat_x);
                        fail_count++;
                    end
                    if (m_data.quat_y !== want.quat_y) begin
                        $display("%0t: quat_y expected %0d actual %0d", $time, want.quat_y, m_data.quat_y);
                        fail_count++;
                    end
                    if (m_data.quat_z !== want.quat_z) begin
                        $display("%0t: quat_z expected %0d actual %0d", $time, want.quat_z, m_data.quat_z);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        angles_t a;
        logic signed [15:0] corner [0:6];
        corner = '{16'sd0, 16'sd25736, -16'sd25736, 16'sh7FFF, 16'sh8000, 16'sd12868, -16'sd12868};
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        // Directed: zero, the pi and half-pi points, the field extremes on each axis.
        for (int i = 0; i < 7; i++) begin
            pending_angles.push_back('{corner[i], 16'sd0, 16'sd0});
            pending_angles.push_back('{16'sd0, corner[i], 16'sd0});
            pending_angles.push_back('{16'sd0, 16'sd0, corner[i]});
        end
        pending_angles.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF});
        pending_angles.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000});
        pending_angles.push_back('{16'sd6434, 16'sd6434, 16'sd6434});
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            a.yaw_angle = pick_angle();
            a.pitch_angle = pick_angle();
            a.roll_angle = pick_angle();
            pending_angles.push_back(a);
            if (i == RANDOM_ITEMS - CALM_ITEMS) begin
                wait (pending_angles.size() <= CALM_ITEMS);
            end
        end
        calm_phase = 1'b1;
        wait (pending_angles.size() == 0 && !s_valid);
        stimulus_done = 1'b1;
        wait (expected_quats.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("euler_to_quaternion regression: pass");
        end else begin
            $display("euler_to_quaternion regression: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("euler_to_quaternion regression: fail");
        $finish;
    end
endmodule
